@@ src/dpf_pkg.sv @@
// Shared constants, register codes and a helper of the delimiter packet framer.
package dpf_pkg;

   localparam int BOUNDARY_MAX_BYTES = 8;
   localparam int HIST_BYTES         = BOUNDARY_MAX_BYTES - 1;
   localparam int HIST_W             = 8 * HIST_BYTES;
   localparam int PATTERN_W          = 8 * BOUNDARY_MAX_BYTES;
   localparam int LEN_CFG_W          = 4;
   localparam int CSR_INDEX_W        = 2;
   localparam int LENGTH_OUT_W       = 15;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_PATTERN = 2'd0;
   localparam csr_index_type CSR_LENGTH  = 2'd1;

   typedef logic [LEN_CFG_W-1:0] len_type;

   localparam len_type LEN_MIN = 4'd1;
   localparam len_type LEN_MAX = 4'd8;

   // Clamps the programmed boundary length into the range one to eight.
   function automatic len_type effective_length(input len_type raw);
      len_type n;
      n = raw;
      if (raw < LEN_MIN) begin
         n = LEN_MIN;
      end else if (raw > LEN_MAX) begin
         n = LEN_MAX;
      end
      return n;
   endfunction

endpackage

@@ src/delimiter_packet_framer.sv @@
// Top level of the delimiter packet framer: byte matching, length count and result register.
//
//   Channel   Direction   Ports
//   request   in          req_valid, req_stall, req_rx_byte
//   result    out         rsp_valid, rsp_stall, rsp_out_byte, rsp_packet_end,
//                         rsp_packet_length, rsp_length_overflow
//   config    in          csr_write_enable, csr_index, csr_write_data
//
// The history and count update at acceptance, and the
// result appears in the output register on the following cycle.
// One request is accepted in every cycle while the result side does not stall.
// A stalled result holds in the output register; the request side stalls only while
// that register is full and stalled.
// Synchronous reset clears the history, the count, the output valid and the registers
// to a single line-feed boundary byte.
module delimiter_packet_framer #(
   parameter int MAX_PACKET_LEN = 16384
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [7:0]                                req_rx_byte,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [7:0]                                rsp_out_byte,
   output logic                                      rsp_packet_end,
   output logic [dpf_pkg::LENGTH_OUT_W-1:0]          rsp_packet_length,
   output logic                                      rsp_length_overflow,
   input  logic                                      csr_write_enable,
   input  dpf_pkg::csr_index_type                    csr_index,
   input  logic [dpf_pkg::PATTERN_W-1:0]             csr_write_data
);

   localparam int CNT_W = $clog2(MAX_PACKET_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PACKET_LEN);

   logic [dpf_pkg::PATTERN_W-1:0] pattern_ff;
   dpf_pkg::len_type              length_ff;
   logic [dpf_pkg::HIST_W-1:0]    hist_ff, hist_in;
   logic [CNT_W-1:0]              count_ff, count_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_byte_ff;
   logic                          rsp_end_ff;
   logic [CNT_W-1:0]              rsp_count_ff;
   logic                          rsp_full_ff;

   logic                          req_take;
   logic                          rsp_take;
   dpf_pkg::len_type              len_eff;
   logic [dpf_pkg::PATTERN_W-1:0] window;
   logic [CNT_W-1:0]              count_next;
   logic                          full;
   logic [dpf_pkg::BOUNDARY_MAX_BYTES-1:0] byte_hit;
   logic                          match;
   logic [CNT_W+dpf_pkg::LENGTH_OUT_W-1:0] length_wide;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   assign len_eff    = dpf_pkg::effective_length(length_ff);
   assign window     = {hist_ff, req_rx_byte};
   assign count_next = (count_ff < CNT_LIMIT) ? count_ff + CNT_W'(1) : count_ff;
   assign full       = (count_next >= CNT_LIMIT);

   always_comb begin
      for (int k = 0; k < dpf_pkg::BOUNDARY_MAX_BYTES; k++) begin
         byte_hit[k] = (window[8*k +: 8] == pattern_ff[8*k +: 8]) ||
                       (k >= int'(len_eff));
      end
   end

   assign match = (&byte_hit) &&
                  (count_next >= {{(CNT_W-dpf_pkg::LEN_CFG_W){1'b0}}, len_eff});

   always_comb begin
      hist_in  = hist_ff;
      count_in = count_ff;
      if (req_take) begin
         if (match) begin
            hist_in  = '0;
            count_in = '0;
         end else begin
            hist_in  = window[dpf_pkg::HIST_W-1:0];
            count_in = count_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= dpf_pkg::PATTERN_W'(10);
         length_ff    <= dpf_pkg::LEN_MIN;
         hist_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               dpf_pkg::CSR_PATTERN: pattern_ff <= csr_write_data;
               dpf_pkg::CSR_LENGTH:  length_ff  <= csr_write_data[dpf_pkg::LEN_CFG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_byte_ff  <= req_rx_byte;
         rsp_end_ff   <= match;
         rsp_count_ff <= count_next;
         rsp_full_ff  <= full;
      end
   end

   assign length_wide = {{dpf_pkg::LENGTH_OUT_W{1'b0}}, rsp_count_ff};

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_byte        = rsp_byte_ff;
   assign rsp_packet_end      = rsp_end_ff;
   assign rsp_packet_length   = length_wide[dpf_pkg::LENGTH_OUT_W-1:0];
   assign rsp_length_overflow = rsp_full_ff;

endmodule

@@ src/dpf_checker.sv @@
// Port-level assertions for the delimiter packet framer and their binding.
module dpf_checker #(
   parameter int MAX_PACKET_LEN = 16384
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [7:0]                          rsp_out_byte,
   input logic                                rsp_packet_end,
   input logic [dpf_pkg::LENGTH_OUT_W-1:0]    rsp_packet_length,
   input logic                                rsp_length_overflow
);

   localparam logic [31:0] LIMIT = 32'(MAX_PACKET_LEN);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("Accepted request gave no result.");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("Request stalled with an empty output register.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_length_overflow) |->
         (rsp_packet_length == LIMIT[dpf_pkg::LENGTH_OUT_W-1:0]))
      else $error("Overflow flag without saturated length.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_packet_end) &&
          $stable(rsp_packet_length) && $stable(rsp_length_overflow)))
      else $error("Stalled result changed.");

endmodule

bind delimiter_packet_framer dpf_checker #(.MAX_PACKET_LEN(MAX_PACKET_LEN)) u_dpf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_byte        (rsp_out_byte),
   .rsp_packet_end      (rsp_packet_end),
   .rsp_packet_length   (rsp_packet_length),
   .rsp_length_overflow (rsp_length_overflow)
);
